### rtl/dhcpos_pkg.sv
// ----------------------------------------------------------------------------
// dhcpos_pkg
// Shared option codes, scan phase type and summary record for the DHCP
// option scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcpos_pkg;

	localparam logic [7:0] CODE_PAD    = 8'd0;
	localparam logic [7:0] CODE_MASK   = 8'd1;
	localparam logic [7:0] CODE_ROUTER = 8'd3;
	localparam logic [7:0] CODE_DNS    = 8'd6;
	localparam logic [7:0] CODE_NTP    = 8'd42;
	localparam logic [7:0] CODE_TYPE   = 8'd53;
	localparam logic [7:0] CODE_END    = 8'hff;
	localparam logic [7:0] KEY_RESET   = 8'd54;

	// found_flags bit positions
	localparam int FB_TYPE   = 0;
	localparam int FB_MASK   = 1;
	localparam int FB_ROUTER = 2;
	localparam int FB_DNS    = 3;
	localparam int FB_NTP    = 4;
	localparam int FB_KEY    = 5;

	localparam int FOUND_W = 6;

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_LEN  = 2'd1,
		PH_VAL  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0]         message_type;
		logic [31:0]        subnet_mask;
		logic [31:0]        router_addr;
		logic [31:0]        dns_addr;
		logic [31:0]        ntp_addr;
		logic [31:0]        key_value;
		logic [FOUND_W-1:0] found_flags;
		logic               truncated;
	} summary_t;

endpackage

`default_nettype wire

### rtl/dhcpos_scan.sv
// ----------------------------------------------------------------------------
// dhcpos_scan
// Input register, option record walker and lookup key register. Produces
// one summary per message on the last byte or on the end option.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpos_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        opt_byte,
	input  wire logic              last_byte,
	input  wire logic              cfg_valid,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              q_room,
	output logic                   res_push,
	output dhcpos_pkg::summary_t   res
);
	import dhcpos_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       proc;

	logic [7:0] key_q;

	// scan state
	phase_t             ph_q, ph_n;
	logic [7:0]         code_q, code_n;
	logic [7:0]         left_q, left_n;
	logic [2:0]         idx_q, idx_n;
	logic [31:0]        acc_q, acc_n;
	logic [7:0]         type_q, type_n;
	logic [31:0]        mask_q, mask_n;
	logic [31:0]        rtr_q, rtr_n;
	logic [31:0]        dns_q, dns_n;
	logic [31:0]        ntp_q, ntp_n;
	logic [31:0]        hkey_q, hkey_n;
	logic [FOUND_W-1:0] fnd_q, fnd_n;
	logic               ended_q, ended_n;

	logic emit;
	logic commit;
	logic done;

	assign proc     = valid_s1 && q_room;
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= opt_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_RESET;
		end else if (cfg_valid) begin
			key_q <= cfg_data;
		end
	end

	always_comb begin
		ph_n    = ph_q;
		code_n  = code_q;
		left_n  = left_q;
		idx_n   = idx_q;
		acc_n   = acc_q;
		type_n  = type_q;
		mask_n  = mask_q;
		rtr_n   = rtr_q;
		dns_n   = dns_q;
		ntp_n   = ntp_q;
		hkey_n  = hkey_q;
		fnd_n   = fnd_q;
		ended_n = ended_q;
		emit    = 1'b0;
		commit  = 1'b0;

		unique case (ph_q)
			PH_LEN: begin
				left_n = byte_s1;
				idx_n  = 3'd0;
				acc_n  = 32'd0;
				if (byte_s1 == 8'd0) begin
					commit = 1'b1;
					ph_n   = PH_CODE;
				end else begin
					ph_n = PH_VAL;
				end
			end
			PH_VAL: begin
				if (!idx_q[2]) begin
					unique case (idx_q[1:0])
						2'd0: acc_n = acc_q | {byte_s1, 24'd0};
						2'd1: acc_n = acc_q | {8'd0, byte_s1, 16'd0};
						2'd2: acc_n = acc_q | {16'd0, byte_s1, 8'd0};
						2'd3: acc_n = acc_q | {24'd0, byte_s1};
					endcase
					idx_n = idx_q + 3'd1;
				end
				left_n = left_q - 8'd1;
				if (left_n == 8'd0) begin
					commit = 1'b1;
					ph_n   = PH_CODE;
				end
			end
			default: begin
				// unused phase code behaves as expecting a code
				ph_n = PH_CODE;
				if (byte_s1 == CODE_END) begin
					emit = 1'b1;
				end else if (byte_s1 != CODE_PAD) begin
					code_n = byte_s1;
					ph_n   = PH_LEN;
				end
			end
		endcase

		if (commit) begin
			if (idx_n != 3'd0) begin
				unique case (code_q)
					CODE_TYPE: begin
						type_n        = acc_n[31:24];
						fnd_n[FB_TYPE] = 1'b1;
					end
					CODE_MASK: begin
						mask_n        = acc_n;
						fnd_n[FB_MASK] = 1'b1;
					end
					CODE_ROUTER: begin
						rtr_n           = acc_n;
						fnd_n[FB_ROUTER] = 1'b1;
					end
					CODE_DNS: begin
						dns_n         = acc_n;
						fnd_n[FB_DNS] = 1'b1;
					end
					CODE_NTP: begin
						ntp_n         = acc_n;
						fnd_n[FB_NTP] = 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (code_q == key_q && !fnd_q[FB_KEY]) begin
				hkey_n        = acc_n;
				fnd_n[FB_KEY] = 1'b1;
			end
		end
	end

	// after end, bytes are dropped until the last byte of the message
	assign done     = emit || last_s1;
	assign res_push = proc && !ended_q && done;

	always_comb begin
		res.message_type = type_n;
		res.subnet_mask  = mask_n;
		res.router_addr  = rtr_n;
		res.dns_addr     = dns_n;
		res.ntp_addr     = ntp_n;
		res.key_value    = hkey_n;
		res.found_flags  = fnd_n;
		res.truncated    = (ph_n != PH_CODE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_CODE;
			code_q  <= 8'd0;
			left_q  <= 8'd0;
			idx_q   <= 3'd0;
			acc_q   <= 32'd0;
			type_q  <= 8'd0;
			mask_q  <= 32'd0;
			rtr_q   <= 32'd0;
			dns_q   <= 32'd0;
			ntp_q   <= 32'd0;
			hkey_q  <= 32'd0;
			fnd_q   <= '0;
			ended_q <= 1'b0;
		end else if (proc) begin
			if (ended_q || done) begin
				ph_q    <= PH_CODE;
				code_q  <= 8'd0;
				left_q  <= 8'd0;
				idx_q   <= 3'd0;
				acc_q   <= 32'd0;
				type_q  <= 8'd0;
				mask_q  <= 32'd0;
				rtr_q   <= 32'd0;
				dns_q   <= 32'd0;
				ntp_q   <= 32'd0;
				hkey_q  <= 32'd0;
				fnd_q   <= '0;
				ended_q <= ended_q ? !last_s1 : (emit && !last_s1);
			end else begin
				ph_q    <= ph_n;
				code_q  <= code_n;
				left_q  <= left_n;
				idx_q   <= idx_n;
				acc_q   <= acc_n;
				type_q  <= type_n;
				mask_q  <= mask_n;
				rtr_q   <= rtr_n;
				dns_q   <= dns_n;
				ntp_q   <= ntp_n;
				hkey_q  <= hkey_n;
				fnd_q   <= fnd_n;
				ended_q <= ended_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_end_sets_ended: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !ended_q && emit && !last_s1 |=> ended_q)
		else $error("end option did not mark the message as ended");

	a_no_push_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !res_push)
		else $error("summary emitted after end option");

	a_idx_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q[2] |-> idx_q[1:0] == 2'd0)
		else $error("value index ran past four");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> q_room)
		else $error("summary pushed with no room");
`endif

endmodule

`default_nettype wire

### rtl/dhcpos_outq.sv
// ----------------------------------------------------------------------------
// dhcpos_outq
// Two-entry result queue. Keeps the scanner running while the receiver
// stalls and keeps out_ready off the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcpos_outq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire dhcpos_pkg::summary_t push_data,
	output logic                      room,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output dhcpos_pkg::summary_t      out_data
);
	import dhcpos_pkg::*;

	summary_t   ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != 2'd2)
		else $error("result queue overflow");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_q == rd_q)
		else $error("result queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

### rtl/dhcp_option_scanner.sv
// ----------------------------------------------------------------------------
// dhcp_option_scanner
// Walks the DHCP options area one byte per transfer and reports the captured
// options once per message.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry opt_byte and last_byte, one byte of
// the options area per transfer. Bytes may come every cycle.
// Output channel: out_valid/out_ready carry one summary per message, sent on
// the byte flagged last_byte or on the end option, whichever comes first.
// Bytes after an end option are dropped until last_byte.
// Config channel: cfg_valid/cfg_ready write lookup_key (reset 54); cfg_ready
// is always high. Write it only between messages.
// Output path: the closing byte is held in the input register, then its
// summary is queued. Throughput: one byte per cycle while the queue has room.
// A two-entry result queue absorbs receiver stalls; in_ready drops only once
// both entries are full and another byte is waiting in the input register.
// Reset clears the scan state, the queue and restores lookup_key to 54.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_option_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  opt_byte,
	input  wire logic        last_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  lookup_key,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       message_type,
	output logic [31:0]      subnet_mask,
	output logic [31:0]      router_addr,
	output logic [31:0]      dns_addr,
	output logic [31:0]      ntp_addr,
	output logic [31:0]      key_value,
	output logic [5:0]       found_flags,
	output logic             truncated
);
	import dhcpos_pkg::*;

	logic     q_room;
	logic     res_push;
	summary_t res;
	summary_t head;

	assign cfg_ready = 1'b1;

	dhcpos_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opt_byte (opt_byte),
		.last_byte(last_byte),
		.cfg_valid(cfg_valid),
		.cfg_data (lookup_key),
		.q_room   (q_room),
		.res_push (res_push),
		.res      (res)
	);

	dhcpos_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res),
		.room     (q_room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (head)
	);

	assign message_type = head.message_type;
	assign subnet_mask  = head.subnet_mask;
	assign router_addr  = head.router_addr;
	assign dns_addr     = head.dns_addr;
	assign ntp_addr     = head.ntp_addr;
	assign key_value    = head.key_value;
	assign found_flags  = head.found_flags;
	assign truncated    = head.truncated;

endmodule

`default_nettype wire
